/* rtl/core/index_sort_by_key_macros.svh */
// Assertion macros for the index sort checker.
`ifndef INDEX_SORT_BY_KEY_MACROS_SVH
`define INDEX_SORT_BY_KEY_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ISBK_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("index sort check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ISBK_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("index sort check failed");

`endif

/* rtl/core/isbk_pkg.sv */
// Types and constants shared by the index sort modules.
package isbk_pkg;
	localparam int IDX_W   = 6;
	localparam int KEY_W   = 48;
	localparam int TDATA_W = 56;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;
endpackage

/* rtl/core/isbk_cell.sv */
// One insertion cell: holds one entry, inserts in key order, shifts toward the head on drain.
module isbk_cell import isbk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    new_entry,
	input  entry_t    prev_entry,
	input  logic      prev_gt,
	input  entry_t    next_entry,
	output entry_t    entry,
	output logic      gt
);
	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] idx_q;

	assign entry = '{valid: valid_q, key: key_q, idx: idx_q};
	// Empty cells count as larger than any key; equal keys stay ahead.
	assign gt    = !valid_q || (key_q > new_entry.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			if (prev_gt) begin
				valid_q <= prev_entry.valid;
			end else if (gt) begin
				valid_q <= 1'b1;
			end
		end else if (ctl.shift) begin
			valid_q <= next_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (prev_gt) begin
				key_q <= prev_entry.key;
				idx_q <= prev_entry.idx;
			end else if (gt) begin
				key_q <= new_entry.key;
				idx_q <= new_entry.idx;
			end
		end else if (ctl.shift) begin
			key_q <= next_entry.key;
			idx_q <= next_entry.idx;
		end
	end
endmodule

/* rtl/core/index_sort_by_key.sv */
// Top level of the stable ascending index sort built from a chain of insertion cells.
//
//   port group  dir  tdata (low bit up)                  tlast
//   s_*         in   entry_index[5:0], sort_key[47:0]    batch_end
//   m_*         out  sorted_index[5:0], sorted_key[47:0] final_result
//
// Load: one beat per cycle; every cell compares against the new key in parallel.
// Drain: after the batch_end beat, one result per cycle shifts out of cell 0;
// s_tready returns once cell 0 is empty.
// s_tready is low while draining; m_tready low while m_tvalid is high holds the chain in place.
// Beats past MAX_ENTRIES are dropped. Reset empties all cells at once.
module index_sort_by_key import isbk_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // entry_index, sort_key, zero pad
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // sorted_index, sorted_key, zero pad
	output logic               m_tlast
);
	entry_t    cell_q [MAX_ENTRIES];
	logic      gt     [MAX_ENTRIES];
	entry_t    new_entry;
	cell_ctl_t ctl;
	logic      s_beat;
	logic      drain_q;
	logic      m_valid_q;
	logic      m_last_q;
	logic [IDX_W-1:0] m_idx_q;
	logic [KEY_W-1:0] m_key_q;

	assign new_entry = '{valid: 1'b1, key: s_tdata[IDX_W+KEY_W-1:IDX_W], idx: s_tdata[IDX_W-1:0]};
	assign s_tready  = !drain_q;
	assign s_beat    = s_tvalid && s_tready;
	assign ctl.load  = s_beat && !cell_q[MAX_ENTRIES-1].valid;
	assign ctl.shift = drain_q && cell_q[0].valid && (!m_valid_q || m_tready);

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		entry_t prev_e;
		logic   prev_g;
		entry_t next_e;
		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_g = 1'b0;
		end else begin : g_body
			assign prev_e = cell_q[i-1];
			assign prev_g = gt[i-1];
		end
		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_inner
			assign next_e = cell_q[i+1];
		end
		isbk_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.prev_gt    (prev_g),
			.next_entry (next_e),
			.entry      (cell_q[i]),
			.gt         (gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_beat && s_tlast) begin
				drain_q <= 1'b1;
			end else if (drain_q && !cell_q[0].valid) begin
				drain_q <= 1'b0;
			end
			if (ctl.shift) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			m_idx_q  <= cell_q[0].idx;
			m_key_q  <= cell_q[0].key;
			m_last_q <= !cell_q[1].valid;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{(TDATA_W-IDX_W-KEY_W){1'b0}}, m_key_q, m_idx_q};
endmodule

/* rtl/core/isbk_checker.sv */
// Port-level checks for the index sort, bound to the top level.
`include "index_sort_by_key_macros.svh"

module isbk_checker import isbk_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [TDATA_W-1:0] s_tdata,
	input logic               s_tlast,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               m_tlast
);
	`ISBK_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	`ISBK_ASSERT_NXT(a_end_stalls_in, s_tvalid && s_tready && s_tlast, !s_tready)
	`ISBK_ASSERT_NXT(a_end_gives_out, s_tvalid && s_tready && s_tlast, ##1 m_tvalid)
	`ISBK_ASSERT_IMP(a_idle_only_final, s_tready && m_tvalid, m_tlast)
endmodule

bind index_sort_by_key isbk_checker u_isbk_checker (.*);
